### design/http_header_line_tokenizer_assert.svh
// Assertion macros used by the tokenizer FSM module.
`ifndef HTTP_HEADER_LINE_TOKENIZER_ASSERT_SVH
`define HTTP_HEADER_LINE_TOKENIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HHLT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hhlt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HHLT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hhlt assertion failed");

`endif

### design/hhlt_pkg.sv
`timescale 1ns / 1ps

package hhlt_pkg;

  typedef enum logic [3:0] {
    KIND_IGNORED = 4'd0,
    KIND_KEY     = 4'd1,
    KIND_COLON   = 4'd2,
    KIND_SPACE   = 4'd3,
    KIND_VALUE   = 4'd4,
    KIND_VCR     = 4'd5,
    KIND_PAIRLF  = 4'd6,
    KIND_ENDCR   = 4'd7,
    KIND_DONE    = 4'd8,
    KIND_ERROR   = 4'd9
  } kind_t;

  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] LIMIT_RESET = 8'd255;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       new_message;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    kind_t      kind;
    logic [8:0] value_length;
  } result_t;

endpackage

### design/hhlt_byte_if.sv
`timescale 1ns / 1ps

interface hhlt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       new_message;

  modport source (output valid, output byte_in, output new_message, input ready);
  modport sink (input valid, input byte_in, input new_message, output ready);
endinterface

### design/hhlt_res_if.sv
`timescale 1ns / 1ps

interface hhlt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [3:0] kind;
  logic [8:0] value_length;

  modport source (output valid, output byte_out, output kind, output value_length,
                  input ready);
  modport sink (input valid, input byte_out, input kind, input value_length,
                output ready);
endinterface

### design/hhlt_cfg_if.sv
`timescale 1ns / 1ps

interface hhlt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_limit;

  modport source (output valid, output value_limit, input ready);
  modport sink (input valid, input value_limit, output ready);
endinterface

### design/http_header_line_tokenizer.sv
// An accepted input byte waits in the input register; its result is loaded into the
// result register once that register has room and waits there for the receiver.
// Throughput: one byte per cycle while the receiver keeps taking results, set by
// the combinational parser update between the input and result registers.
// Reset (synchronous, active high) returns the parser to line start, clears the
// value count, empties both registers and sets the value limit to 255.
`timescale 1ns / 1ps

module http_header_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  hhlt_byte_if.sink   in_ch,
  hhlt_res_if.source  out_ch,
  hhlt_cfg_if.sink    cfg
);

  logic              in_valid;
  hhlt_pkg::item_t   item;
  hhlt_pkg::result_t res;
  logic              room;
  logic              advance;
  logic [7:0]        limit;

  assign cfg.ready = 1'b1;
  assign advance   = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hhlt_pkg::LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      limit <= cfg.value_limit;
    end
  end

  hhlt_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .advance (advance),
    .valid   (in_valid),
    .item    (item)
  );

  hhlt_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .limit   (limit),
    .res     (res)
  );

  hhlt_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

### design/hhlt_in_reg.sv
`timescale 1ns / 1ps

module hhlt_in_reg (
  input  logic             clk,
  input  logic             rst,
  hhlt_byte_if.sink        in_ch,
  input  logic             advance,
  output logic             valid,
  output hhlt_pkg::item_t  item
);

  logic take;

  assign in_ch.ready = !valid || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.byte_in     <= in_ch.byte_in;
      item.new_message <= in_ch.new_message;
    end
  end

endmodule

### design/hhlt_fsm.sv
`timescale 1ns / 1ps

module hhlt_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  hhlt_pkg::item_t   item,
  input  logic [7:0]        limit,
  output hhlt_pkg::result_t res
);

  `include "http_header_line_tokenizer_assert.svh"

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_DONE   = 4'd8,
    ST_ERROR  = 4'd9
  } state_t;

  state_t     state;
  state_t     state_next;
  state_t     state_eff;
  logic [8:0] count;
  logic [8:0] count_next;
  logic [8:0] count_eff;
  logic       crlf;
  logic [7:0] b;

  assign b         = item.byte_in;
  assign crlf      = b inside {hhlt_pkg::CH_CR, hhlt_pkg::CH_LF};
  assign state_eff = item.new_message ? ST_START : state;
  assign count_eff = item.new_message ? 9'd0 : count;

  always_comb begin
    state_next       = ST_ERROR;
    count_next       = count_eff;
    res.byte_out     = b;
    res.kind         = hhlt_pkg::KIND_ERROR;
    res.value_length = 9'd0;
    case (state_eff)
      ST_START: begin
        if (crlf) begin
          res.kind   = hhlt_pkg::KIND_IGNORED;
          state_next = ST_START;
        end else begin
          res.kind   = hhlt_pkg::KIND_KEY;
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        if (b == hhlt_pkg::CH_COLON) begin
          res.kind   = hhlt_pkg::KIND_COLON;
          state_next = ST_COLON;
        end else if (!crlf) begin
          res.kind   = hhlt_pkg::KIND_KEY;
          state_next = ST_KEY;
        end
      end
      ST_COLON: begin
        if (b == hhlt_pkg::CH_SPACE) begin
          res.kind   = hhlt_pkg::KIND_SPACE;
          state_next = ST_SPACE;
        end
      end
      ST_SPACE: begin
        res.kind   = hhlt_pkg::KIND_VALUE;
        count_next = 9'd1;
        state_next = ST_VALUE;
      end
      ST_VALUE: begin
        if (b == hhlt_pkg::CH_CR) begin
          res.kind   = hhlt_pkg::KIND_VCR;
          state_next = ST_CR;
        end else if (count_eff <= {1'b0, limit}) begin
          res.kind   = hhlt_pkg::KIND_VALUE;
          count_next = count_eff + 9'd1;
          state_next = ST_VALUE;
        end
      end
      ST_CR: begin
        if (b == hhlt_pkg::CH_LF) begin
          res.kind         = hhlt_pkg::KIND_PAIRLF;
          res.value_length = count_eff;
          state_next       = ST_LF;
        end
      end
      ST_LF: begin
        if (b == hhlt_pkg::CH_CR) begin
          res.kind   = hhlt_pkg::KIND_ENDCR;
          state_next = ST_END_CR;
        end else if (b != hhlt_pkg::CH_LF) begin
          res.kind   = hhlt_pkg::KIND_KEY;
          state_next = ST_KEY;
        end
      end
      ST_END_CR: begin
        if (b == hhlt_pkg::CH_LF) begin
          res.kind   = hhlt_pkg::KIND_DONE;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res.kind   = hhlt_pkg::KIND_DONE;
        state_next = ST_DONE;
      end
      default: begin
        state_next = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      count <= 9'd0;
    end else if (advance) begin
      state <= state_next;
      count <= count_next;
    end
  end

  `HHLT_ASSERT_IMP(a_len_only_on_pair, clk, rst, res.value_length != 9'd0, res.kind == hhlt_pkg::KIND_PAIRLF)
  `HHLT_ASSERT_NXT(a_error_sticky, clk, rst, state == ST_ERROR && !(advance && item.new_message), state == ST_ERROR)
  `HHLT_ASSERT_IMP(a_done_reported, clk, rst, state == ST_DONE && !item.new_message, res.kind == hhlt_pkg::KIND_DONE)
  `HHLT_ASSERT_NXT(a_restart_clears, clk, rst, advance && item.new_message, count == 9'd0)

endmodule

### design/hhlt_out_reg.sv
`timescale 1ns / 1ps

module hhlt_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hhlt_pkg::result_t res,
  output logic              room,
  hhlt_res_if.source        out_ch
);

  logic              valid;
  hhlt_pkg::result_t data;

  assign room                = !valid || out_ch.ready;
  assign out_ch.valid        = valid;
  assign out_ch.byte_out     = data.byte_out;
  assign out_ch.kind         = data.kind;
  assign out_ch.value_length = data.value_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule
